// ===== src/lcdcwd_pkg.sv =====
package lcdcwd_pkg;

    localparam int DEFAULT_COORD_BITS = 10;
    localparam int WIN_W  = 10;
    localparam int SIZE_W = 11;
    localparam int HOLD_W = 8;
    localparam int PCNT_W = 3;

    localparam logic [SIZE_W-1:0] RST_BUFFER_WIDTH  = 11'd240;
    localparam logic [SIZE_W-1:0] RST_BUFFER_HEIGHT = 11'd320;

    // configuration register indexes
    localparam logic [1:0] CFG_BUFFER_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_BUFFER_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_SWAP_RED_BLUE  = 2'd2;
    localparam logic [1:0] CFG_PANEL_INVERTED = 2'd3;

    // bus commands
    localparam logic [7:0] CMD_NOP         = 8'h00;
    localparam logic [7:0] CMD_SWRESET     = 8'h01;
    localparam logic [7:0] CMD_WAKE        = 8'h11;
    localparam logic [7:0] CMD_INV_CLEAR   = 8'h20;
    localparam logic [7:0] CMD_INV_SET     = 8'h21;
    localparam logic [7:0] CMD_DISP_ENABLE = 8'h29;
    localparam logic [7:0] CMD_COL_BOUNDS  = 8'h2A;
    localparam logic [7:0] CMD_ROW_BOUNDS  = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
    localparam logic [7:0] CMD_ORIENT      = 8'h36;
    localparam logic [7:0] CMD_PIX_FORMAT  = 8'h3A;
    localparam logic [7:0] CMD_MEM_CONTROL = 8'hB0;

    // orientation byte bit positions
    localparam int OR_BGR_BIT = 3;
    localparam int OR_MV_BIT  = 5;
    localparam int OR_MX_BIT  = 6;
    localparam int OR_MY_BIT  = 7;

    // endian bit in the second RAM control byte
    localparam int ENDIAN_BIT = 3;

    // status bit positions
    localparam int ST_ON_BIT    = 0;
    localparam int ST_SLEEP_BIT = 1;
    localparam int ST_INV_BIT   = 2;

    // pixel format codes on the bus
    localparam logic [2:0] COLMOD_RGB111 = 3'h1;
    localparam logic [2:0] COLMOD_RGB444 = 3'h3;
    localparam logic [2:0] COLMOD_RGB565 = 3'h5;
    localparam logic [2:0] COLMOD_RGB666 = 3'h6;

    localparam logic [1:0] FMT_RGB111 = 2'd0;
    localparam logic [1:0] FMT_RGB444 = 2'd1;
    localparam logic [1:0] FMT_RGB565 = 2'd2;
    localparam logic [1:0] FMT_RGB666 = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] buffer_width;
        logic [SIZE_W-1:0] buffer_height;
        logic              swap_red_blue;
        logic              panel_inverted;
    } t_cfg;

    typedef struct packed {
        logic              ram_write_active;
        logic [2:0]        display_flags;
        logic              little_endian;
        logic [1:0]        pixel_format;
        logic              bgr_order;
        logic [2:0]        orientation;
        logic [WIN_W-1:0]  win_y_end;
        logic [WIN_W-1:0]  win_y_start;
        logic [WIN_W-1:0]  win_x_end;
        logic [WIN_W-1:0]  win_x_start;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== src/lcdcwd_core.sv =====
module lcdcwd_core #(
    parameter int COORD_BITS = lcdcwd_pkg::DEFAULT_COORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic                 i_is_data,
    input  logic [7:0]           i_bus_byte,
    input  lcdcwd_pkg::t_cfg     i_cfg,
    output lcdcwd_pkg::t_result  o_result
);
    import lcdcwd_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int VAL_W  = 2 * HOLD_W;
    localparam int unsigned FULL_SIZE = 1 << COORD_BITS;

    // last valid coordinate for a buffer size, with out-of-range sizes pinned
    function automatic logic [CB-1:0] size_hi(input logic [SIZE_W-1:0] v);
        logic [CB-1:0] h;
        if (v == '0) begin
            h = '0;
        end else if (32'(v) > FULL_SIZE) begin
            h = '1;
        end else begin
            h = CB'(v - SIZE_W'(1));
        end
        return h;
    endfunction

    logic [7:0]        r_orient,   n_orient;
    logic [CB-1:0]     r_cs,       n_cs;
    logic [CB-1:0]     r_ce,       n_ce;
    logic [CB-1:0]     r_rs,       n_rs;
    logic [CB-1:0]     r_re,       n_re;
    logic [7:0]        r_cmd,      n_cmd;
    logic [PCNT_W-1:0] r_pcnt,     n_pcnt;
    logic [HOLD_W-1:0] r_hold,     n_hold;
    logic [CB-1:0]     r_lxs,      n_lxs;
    logic [CB-1:0]     r_lxe,      n_lxe;
    logic [CB-1:0]     r_lys,      n_lys;
    logic [CB-1:0]     r_lye,      n_lye;
    logic              r_bgr,      n_bgr;
    logic [1:0]        r_fmt,      n_fmt;
    logic              r_endian,   n_endian;
    logic [2:0]        r_status,   n_status;

    logic              refresh;
    logic              is_col;
    logic              to_col;
    logic [CB-1:0]     hi_w;
    logic [CB-1:0]     hi_h;
    logic [CB-1:0]     hi_t;
    logic [VAL_W-1:0]  val;
    logic [VAL_W-1:0]  hi16;
    logic [VAL_W-1:0]  lo16;
    logic [VAL_W-1:0]  raised;
    logic [CB-1:0]     start_clamp;
    logic [CB-1:0]     end_clamp;

    assign hi_w   = size_hi(i_cfg.buffer_width);
    assign hi_h   = size_hi(i_cfg.buffer_height);
    assign is_col = (r_cmd == CMD_COL_BOUNDS);
    assign to_col = is_col ^ r_orient[OR_MV_BIT];
    assign hi_t   = to_col ? hi_w : hi_h;
    assign val    = {r_hold, i_bus_byte};
    assign hi16   = VAL_W'(hi_t);
    assign lo16   = to_col ? VAL_W'(r_cs) : VAL_W'(r_rs);
    assign raised = (val < lo16) ? lo16 : val;

    assign start_clamp = (val > hi16) ? hi_t : CB'(val);
    assign end_clamp   = (raised > hi16) ? hi_t : CB'(raised);

    always_comb begin
        n_orient = r_orient;
        n_cs     = r_cs;
        n_ce     = r_ce;
        n_rs     = r_rs;
        n_re     = r_re;
        n_cmd    = r_cmd;
        n_pcnt   = r_pcnt;
        n_hold   = r_hold;
        n_fmt    = r_fmt;
        n_endian = r_endian;
        n_status = r_status;
        refresh  = 1'b0;

        if (!i_is_data) begin
            n_cmd  = i_bus_byte;
            n_pcnt = '0;
            unique case (i_bus_byte)
                CMD_SWRESET: begin
                    n_orient = '0;
                    n_cs     = '0;
                    n_ce     = hi_w;
                    n_rs     = '0;
                    n_re     = hi_h;
                    n_status = '0;
                    n_status[ST_SLEEP_BIT] = 1'b1;
                    n_status[ST_INV_BIT]   = i_cfg.panel_inverted;
                    n_fmt    = FMT_RGB565;
                end
                CMD_WAKE:        n_status[ST_SLEEP_BIT] = 1'b0;
                CMD_INV_CLEAR:   n_status[ST_INV_BIT] = i_cfg.panel_inverted;
                CMD_INV_SET:     n_status[ST_INV_BIT] = !i_cfg.panel_inverted;
                CMD_DISP_ENABLE: n_status[ST_ON_BIT] = 1'b1;
                CMD_MEM_WRITE:   refresh = 1'b1;
                default: ;
            endcase
        end else begin
            unique case (r_cmd)
                CMD_ORIENT: begin
                    if (r_pcnt == PCNT_W'(0)) begin
                        n_orient = i_bus_byte;
                        refresh  = 1'b1;
                    end
                end
                CMD_MEM_CONTROL: begin
                    if (r_pcnt == PCNT_W'(1)) begin
                        n_endian = i_bus_byte[ENDIAN_BIT];
                    end
                end
                CMD_PIX_FORMAT: begin
                    if (r_pcnt == PCNT_W'(0)) begin
                        // unknown codes keep the old format
                        unique case (i_bus_byte[2:0])
                            COLMOD_RGB111: n_fmt = FMT_RGB111;
                            COLMOD_RGB444: n_fmt = FMT_RGB444;
                            COLMOD_RGB565: n_fmt = FMT_RGB565;
                            COLMOD_RGB666: n_fmt = FMT_RGB666;
                            default: ;
                        endcase
                    end
                end
                CMD_COL_BOUNDS, CMD_ROW_BOUNDS: begin
                    // each bound is sent high byte first, start bound before end bound
                    if (r_pcnt == PCNT_W'(0) || r_pcnt == PCNT_W'(2)) begin
                        n_hold = i_bus_byte;
                    end else if (r_pcnt == PCNT_W'(1)) begin
                        if (to_col) begin
                            n_cs = start_clamp;
                        end else begin
                            n_rs = start_clamp;
                        end
                    end else if (r_pcnt == PCNT_W'(3)) begin
                        if (to_col) begin
                            n_ce = end_clamp;
                        end else begin
                            n_re = end_clamp;
                        end
                    end
                end
                default: ;
            endcase
            if (r_pcnt != '1) begin
                n_pcnt = r_pcnt + PCNT_W'(1);
            end
        end
    end

    // on a refresh, cache the logical window (routed by swap) and the BGR order
    always_comb begin
        n_lxs = r_lxs;
        n_lxe = r_lxe;
        n_lys = r_lys;
        n_lye = r_lye;
        n_bgr = r_bgr;
        if (refresh) begin
            if (!n_orient[OR_MV_BIT]) begin
                n_lxs = n_cs;
                n_lxe = n_ce;
                n_lys = n_rs;
                n_lye = n_re;
            end else begin
                n_lxs = n_rs;
                n_lxe = n_re;
                n_lys = n_cs;
                n_lye = n_ce;
            end
            n_bgr = n_orient[OR_BGR_BIT] ^ i_cfg.swap_red_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= '0;
            r_cs     <= '0;
            r_ce     <= size_hi(RST_BUFFER_WIDTH);
            r_rs     <= '0;
            r_re     <= size_hi(RST_BUFFER_HEIGHT);
            r_cmd    <= CMD_NOP;
            r_pcnt   <= '0;
            r_hold   <= '0;
            r_lxs    <= '0;
            r_lxe    <= size_hi(RST_BUFFER_WIDTH);
            r_lys    <= '0;
            r_lye    <= size_hi(RST_BUFFER_HEIGHT);
            r_bgr    <= 1'b0;
            r_fmt    <= FMT_RGB565;
            r_endian <= 1'b0;
            r_status <= 3'b010;
        end else if (i_acc) begin
            r_orient <= n_orient;
            r_cs     <= n_cs;
            r_ce     <= n_ce;
            r_rs     <= n_rs;
            r_re     <= n_re;
            r_cmd    <= n_cmd;
            r_pcnt   <= n_pcnt;
            r_hold   <= n_hold;
            r_lxs    <= n_lxs;
            r_lxe    <= n_lxe;
            r_lys    <= n_lys;
            r_lye    <= n_lye;
            r_bgr    <= n_bgr;
            r_fmt    <= n_fmt;
            r_endian <= n_endian;
            r_status <= n_status;
        end
    end

    always_comb begin
        o_result.win_x_start      = WIN_W'(n_lxs);
        o_result.win_x_end        = WIN_W'(n_lxe);
        o_result.win_y_start      = WIN_W'(n_lys);
        o_result.win_y_end        = WIN_W'(n_lye);
        o_result.orientation      = {n_orient[OR_MY_BIT], n_orient[OR_MX_BIT],
                                     n_orient[OR_MV_BIT]};
        o_result.bgr_order        = n_bgr;
        o_result.pixel_format     = n_fmt;
        o_result.little_endian    = n_endian;
        o_result.display_flags    = n_status;
        o_result.ram_write_active = (n_cmd == CMD_MEM_WRITE);
    end

`ifndef SYNTHESIS
    a_cmd_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && !i_is_data) |=> (r_pcnt == '0))
        else $error("parameter count not cleared by command");

    a_swreset_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && !i_is_data && i_bus_byte == CMD_SWRESET)
            |=> (r_fmt == FMT_RGB565 && r_orient == '0 && r_cs == '0 && r_rs == '0))
        else $error("soft reset left state behind");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_is_data && r_pcnt == '1) |=> (r_pcnt == '1))
        else $error("parameter count wrapped");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_acc |=> ($stable(r_cmd) && $stable(r_status) && $stable(r_lxs)))
        else $error("state moved without a request");
`endif

endmodule

// ===== src/lcd_command_window_decoder_top.sv =====
// LCD command/window decoder.
// Slave stream: one display-bus byte per request; tuser = 1 marks a parameter
// data byte, 0 a command byte. Master stream: one result per request with the
// cached logical window, cached BGR order and the live orientation, pixel
// format, endian, status and RAM-write flags.
// Configuration: write buffer width/height, red/blue swap and panel inversion
// through i_cfg_we/i_cfg_addr/i_cfg_wdata while no request is in flight.
// Output: a request's result is registered into the result register, or into
// the skid register on a stall. Throughput: one request per cycle while ready
// is high; decode is one combinational pass from state registers to result.
// A two-entry output (result register plus skid register) lets a request be
// taken while an earlier result is still waiting; o_s_tready drops only when
// both entries are full, and rises again once the receiver takes a result.
// Reset (synchronous, active low): 240x320 buffer, full window, sleeping,
// display off, RGB565, no pending results.
module lcd_command_window_decoder_top #(
    parameter int COORD_BITS = lcdcwd_pkg::DEFAULT_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,  // bus_byte
    input  logic                               i_s_tuser,  // is_data
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // win_x_start, win_x_end, win_y_start, win_y_end, orientation, bgr_order,
    // pixel_format, little_endian, display_flags, ram_write_active, zero pad
    output logic [lcdcwd_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_addr,
    input  logic [lcdcwd_pkg::SIZE_W-1:0]      i_cfg_wdata
);
    import lcdcwd_pkg::*;

    t_cfg    r_cfg;
    t_result core_res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_v;
    logic    r_skid_v;
    logic    acc;
    logic    out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_width   <= RST_BUFFER_WIDTH;
            r_cfg.buffer_height  <= RST_BUFFER_HEIGHT;
            r_cfg.swap_red_blue  <= 1'b0;
            r_cfg.panel_inverted <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BUFFER_WIDTH:   r_cfg.buffer_width   <= i_cfg_wdata;
                CFG_BUFFER_HEIGHT:  r_cfg.buffer_height  <= i_cfg_wdata;
                CFG_SWAP_RED_BLUE:  r_cfg.swap_red_blue  <= i_cfg_wdata[0];
                CFG_PANEL_INVERTED: r_cfg.panel_inverted <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = !r_skid_v;
    assign acc        = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_v || i_m_tready;

    lcdcwd_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_is_data  (i_s_tuser),
        .i_bus_byte (i_s_tdata),
        .i_cfg      (r_cfg),
        .o_result   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            // drain the skid entry first, otherwise take the new result
            r_out_v  <= r_skid_v || acc;
            r_skid_v <= 1'b0;
        end else if (acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : core_res;
        end
        if (!out_free && acc) begin
            r_skid <= core_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = M_TDATA_W'(r_out);

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full while output register empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_out_v && !i_m_tready) |=> (r_skid_v && r_out_v))
        else $error("request during stall not held in skid entry");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_m_tready) |=> (r_out_v && !r_skid_v))
        else $error("skid entry not moved to output");
`endif

endmodule
